>>> design/guide_line_snap_assert.svh
// ----------------------------------------------------------------------------
// guide line snap assertion macros
// shared assertion forms, clocked on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef GUIDE_LINE_SNAP_ASSERT_SVH
`define GUIDE_LINE_SNAP_ASSERT_SVH

// clocked property, idle during reset
`define GLS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("guide_line_snap: assertion failed");

// implication form, antecedent and consequent given apart
`define GLS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("guide_line_snap: implication failed");

`endif

>>> design/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// types and constants shared by the guide line snap modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gls_pkg;

	localparam int COORD_W = 32;
	localparam int RAD_W   = 31;
	localparam int MODE_W  = 3;
	localparam int SQ_W    = 2 * RAD_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_QUERY = 3'd0,
		MODE_ADD_H = 3'd1,
		MODE_ADD_V = 3'd2,
		MODE_CLR_H = 3'd3,
		MODE_CLR_V = 3'd4
	} mode_t;

	// control from the sequencer to a nearest-line unit
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

endpackage

`default_nettype wire

>>> design/guide_line_snap.sv
// ----------------------------------------------------------------------------
// guide_line_snap
// guide line tables with nearest line snapping of a query point
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  in       in   in_valid/in_ready   mode point_x point_y snap_radius line_position
//  out      out  out_valid/out_ready snapped_x snapped_y found to_point status
//
// a query makes one ram read per table entry plus a closing compare, both tables
// scanned side by side, then three passes of one shared squaring multiplier and
// a decide step. adds and clears go from idle straight to the final state.
// reset empties both tables (counts to zero); entries are not cleared.
// in_ready is low while a word is in work; a finished word waits in the output
// register, so the next word may be taken while the last result is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module guide_line_snap #(
	parameter int MAX_LINES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic        [gls_pkg::MODE_W-1:0]  mode,
	input  logic signed [gls_pkg::COORD_W-1:0] point_x,
	input  logic signed [gls_pkg::COORD_W-1:0] point_y,
	input  logic        [gls_pkg::RAD_W-1:0]   snap_radius,
	input  logic signed [gls_pkg::COORD_W-1:0] line_position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [gls_pkg::COORD_W-1:0] snapped_x,
	output logic signed [gls_pkg::COORD_W-1:0] snapped_y,
	output logic                               found,
	output logic                               to_point,
	output logic                               status
);

	import gls_pkg::*;

	localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW = $clog2(MAX_LINES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_R,
		ST_DECIDE,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [CW-1:0]      hcnt_q, vcnt_q, idx_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [RAD_W-1:0]   r_q;
	logic               rdv_h_s1, rdv_v_s1;
	logic [SQ_W-1:0]    prod_q;
	logic [SQ_W:0]      sum_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic               pend_found_q, pend_tp_q, pend_status_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic               out_found_q, out_tp_q, out_status_q;

	logic               accept;
	logic               h_full, v_full;
	logic               add_h, add_v;
	logic               issue_h, issue_v;
	logic [AW-1:0]      addr_h, addr_v;
	logic [COORD_W-1:0] rd_h, rd_v;
	scan_ctl_t          ctl_h, ctl_v;
	logic               hit_h, hit_v;
	logic [RAD_W-1:0]   dist_h, dist_v;
	logic [COORD_W-1:0] best_h, best_v;
	logic [RAD_W-1:0]   mul_op;
	logic               both, exceed, restore_x, restore_y;
	logic               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign h_full   = (hcnt_q == CW'(MAX_LINES));
	assign v_full   = (vcnt_q == CW'(MAX_LINES));
	assign add_h    = accept && (mode == MODE_ADD_H) && !h_full;
	assign add_v    = accept && (mode == MODE_ADD_V) && !v_full;
	assign issue_h  = (state_q == ST_SCAN) && (idx_q < hcnt_q);
	assign issue_v  = (state_q == ST_SCAN) && (idx_q < vcnt_q);
	assign addr_h   = add_h ? hcnt_q[AW-1:0] : idx_q[AW-1:0];
	assign addr_v   = add_v ? vcnt_q[AW-1:0] : idx_q[AW-1:0];
	assign out_free = !out_valid_q || out_ready;

	gls_ram #(.WIDTH(COORD_W), .DEPTH(MAX_LINES)) u_ram_h (
		.clk   (clk),
		.we    (add_h),
		.addr  (addr_h),
		.wdata (line_position),
		.rdata (rd_h)
	);

	gls_ram #(.WIDTH(COORD_W), .DEPTH(MAX_LINES)) u_ram_v (
		.clk   (clk),
		.we    (add_v),
		.addr  (addr_v),
		.wdata (line_position),
		.rdata (rd_v)
	);

	assign ctl_h = '{clear: accept, step: rdv_h_s1};
	assign ctl_v = '{clear: accept, step: rdv_v_s1};

	// horizontal lines hold y positions
	gls_near u_near_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_h),
		.pos       (py_q),
		.line      (rd_h),
		.radius    (r_q),
		.hit       (hit_h),
		.near_dist (dist_h),
		.line_best (best_h)
	);

	gls_near u_near_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_v),
		.pos       (px_q),
		.line      (rd_v),
		.radius    (r_q),
		.hit       (hit_v),
		.near_dist (dist_v),
		.line_best (best_v)
	);

	// shared squaring unit
	always_comb begin
		unique case (state_q)
			ST_SQ_X: mul_op = dist_v;
			ST_SQ_Y: mul_op = dist_h;
			default: mul_op = r_q;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= SQ_W'(mul_op) * SQ_W'(mul_op);
		if (state_q == ST_SQ_Y) begin
			sum_q <= {1'b0, prod_q};
		end else if (state_q == ST_SQ_R) begin
			sum_q <= sum_q + {1'b0, prod_q};
		end
	end

	assign both      = hit_h && hit_v;
	assign exceed    = both && (sum_q > {1'b0, prod_q});
	assign restore_y = exceed && (dist_v < dist_h);
	assign restore_x = exceed && !(dist_v < dist_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			hcnt_q        <= '0;
			vcnt_q        <= '0;
			idx_q         <= '0;
			px_q          <= '0;
			py_q          <= '0;
			r_q           <= '0;
			rdv_h_s1      <= 1'b0;
			rdv_v_s1      <= 1'b0;
			pend_x_q      <= '0;
			pend_y_q      <= '0;
			pend_found_q  <= 1'b0;
			pend_tp_q     <= 1'b0;
			pend_status_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_found_q   <= 1'b0;
			out_tp_q      <= 1'b0;
			out_status_q  <= 1'b0;
		end else begin
			rdv_h_s1 <= issue_h;
			rdv_v_s1 <= issue_v;
			// in the final state the output register is reloaded below instead
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_q          <= point_x;
						py_q          <= point_y;
						r_q           <= snap_radius;
						idx_q         <= '0;
						pend_x_q      <= point_x;
						pend_y_q      <= point_y;
						pend_found_q  <= 1'b0;
						pend_tp_q     <= 1'b0;
						pend_status_q <= ((mode == MODE_ADD_H) && h_full) ||
							((mode == MODE_ADD_V) && v_full);
						state_q       <= (mode == MODE_QUERY) ? ST_SCAN : ST_FIN;
						case (mode)
							MODE_ADD_H: begin
								if (!h_full) begin
									hcnt_q <= hcnt_q + 1'b1;
								end
							end
							MODE_ADD_V: begin
								if (!v_full) begin
									vcnt_q <= vcnt_q + 1'b1;
								end
							end
							MODE_CLR_H: hcnt_q <= '0;
							MODE_CLR_V: vcnt_q <= '0;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// the idle scan cycle lets the last read finish its compare
					if (issue_h || issue_v) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_SQ_X;
					end
				end
				ST_SQ_X: state_q <= ST_SQ_Y;
				ST_SQ_Y: state_q <= ST_SQ_R;
				ST_SQ_R: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					pend_x_q     <= (hit_v && !restore_x) ? best_v : px_q;
					pend_y_q     <= (hit_h && !restore_y) ? best_h : py_q;
					pend_found_q <= hit_h || hit_v;
					pend_tp_q    <= both;
					state_q      <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_x_q      <= pend_x_q;
						out_y_q      <= pend_y_q;
						out_found_q  <= pend_found_q;
						out_tp_q     <= pend_tp_q;
						out_status_q <= pend_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign snapped_x = out_x_q;
	assign snapped_y = out_y_q;
	assign found     = out_found_q;
	assign to_point  = out_tp_q;
	assign status    = out_status_q;

endmodule

`default_nettype wire

>>> design/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram
// single port ram, one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

>>> design/gls_near.sv
// ----------------------------------------------------------------------------
// gls_near
// nearest line tracker: one table entry compared per step against the best
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gls_near (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gls_pkg::scan_ctl_t                 ctl,
	input  logic signed [gls_pkg::COORD_W-1:0] pos,
	input  logic        [gls_pkg::COORD_W-1:0] line,
	input  logic        [gls_pkg::RAD_W-1:0]   radius,
	output logic                               hit,
	output logic        [gls_pkg::RAD_W-1:0]   near_dist,
	output logic        [gls_pkg::COORD_W-1:0] line_best
);

	import gls_pkg::*;

	logic signed [COORD_W:0] diff;
	logic        [COORD_W:0] abs_d;
	logic                    in_rad;
	logic                    better;
	logic                    take;
	logic                    hit_q;
	logic [RAD_W-1:0]        dist_q;
	logic [COORD_W-1:0]      line_q;

	assign diff   = {pos[COORD_W-1], pos} - {line[COORD_W-1], line};
	assign abs_d  = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
	assign in_rad = abs_d < {{(COORD_W+1-RAD_W){1'b0}}, radius};
	// strict compare keeps the first of equal candidates
	assign better = !hit_q || (abs_d[RAD_W-1:0] < dist_q);
	assign take   = ctl.step && in_rad && better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dist_q <= abs_d[RAD_W-1:0];
			line_q <= line;
		end
	end

	assign hit       = hit_q;
	assign near_dist = dist_q;
	assign line_best = line_q;

endmodule

`default_nettype wire

>>> design/gls_checker.sv
// ----------------------------------------------------------------------------
// gls_checker
// port level checks for guide_line_snap, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "guide_line_snap_assert.svh"

module gls_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [gls_pkg::COORD_W-1:0] snapped_x,
	input logic signed [gls_pkg::COORD_W-1:0] snapped_y,
	input logic                               found,
	input logic                               to_point,
	input logic                               status
);

	// a stalled result word holds
	`GLS_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(snapped_x) && $stable(snapped_y) && $stable(found) && $stable(to_point) && $stable(status)))

	// both axes snapped implies something was found
	`GLS_ASSERT_IMP(a_point_found, out_valid && to_point, found)

	// a refused add never carries a snap
	`GLS_ASSERT_IMP(a_status_nosnap, out_valid && status, !found && !to_point)

	// in_ready is low in the cycle after a word is taken
	`GLS_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready)

endmodule

bind guide_line_snap gls_checker u_gls_checker (.*);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// guide_line_snap testbench
// drives adds, clears and snap queries through the valid/ready channels,
// predicts every result word from a local copy of both line tables and
// checks each one in order; idle and stall rates change over the run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import gls_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int RANDOM_ITEMS = 950;
	localparam int HOLD_AT      = 750;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 100;

	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic [RAD_W-1:0]          RAD_MAX   = 31'h7FFF_FFFF;

	typedef struct {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic                      found;
		logic                      to_point;
		logic                      status;
	} snap_word_t;

	class snap_scoreboard;
		logic signed [COORD_W-1:0] h_lines [TABLE_DEPTH];
		logic signed [COORD_W-1:0] v_lines [TABLE_DEPTH];
		int unsigned               h_count;
		int unsigned               v_count;
		int unsigned               failures;
		snap_word_t                pending_q [$];

		function new();
			h_count  = 0;
			v_count  = 0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t ns: %s", $time, msg);
			failures++;
		endtask

		// nearest line strictly inside the radius, earliest entry wins a tie
		function bit nearest_line(bit horiz, logic signed [COORD_W-1:0] p,
				longint unsigned r, output longint unsigned best_d,
				output logic signed [COORD_W-1:0] best_pos);
			longint                    diff;
			longint unsigned           abs_d;
			logic signed [COORD_W-1:0] pos;
			int unsigned               n;
			bit                        hit;
			hit      = 1'b0;
			best_d   = 0;
			best_pos = '0;
			n        = horiz ? h_count : v_count;
			for (int i = 0; i < n; i++) begin
				pos   = horiz ? h_lines[i] : v_lines[i];
				diff  = longint'(p) - longint'(pos);
				abs_d = (diff < 0) ? -diff : diff;
				if (abs_d < r && (!hit || abs_d < best_d)) begin
					hit      = 1'b1;
					best_d   = abs_d;
					best_pos = pos;
				end
			end
			return hit;
		endfunction

		function void note_word(logic [MODE_W-1:0] m, logic signed [COORD_W-1:0] px,
				logic signed [COORD_W-1:0] py, logic [RAD_W-1:0] r,
				logic signed [COORD_W-1:0] pos);
			snap_word_t                w;
			longint unsigned           dx, dy, rad;
			logic signed [COORD_W-1:0] lx, ly;
			bit                        hx, hy;
			w.sx       = px;
			w.sy       = py;
			w.found    = 1'b0;
			w.to_point = 1'b0;
			w.status   = 1'b0;
			rad        = r;
			case (m)
				MODE_QUERY: begin
					hy = nearest_line(1'b1, py, rad, dy, ly);
					hx = nearest_line(1'b0, px, rad, dx, lx);
					if (hy)
						w.sy = ly;
					if (hx)
						w.sx = lx;
					if (hx && hy) begin
						// move longer than the radius: the farther axis goes back, x on a tie
						if (dx * dx + dy * dy > rad * rad) begin
							if (dx < dy)
								w.sy = py;
							else
								w.sx = px;
						end
						w.to_point = 1'b1;
					end
					w.found = hx || hy;
				end
				MODE_ADD_H: begin
					if (h_count >= TABLE_DEPTH) begin
						w.status = 1'b1;
					end else begin
						h_lines[h_count] = pos;
						h_count++;
					end
				end
				MODE_ADD_V: begin
					if (v_count >= TABLE_DEPTH) begin
						w.status = 1'b1;
					end else begin
						v_lines[v_count] = pos;
						v_count++;
					end
				end
				MODE_CLR_H: h_count = 0;
				MODE_CLR_V: v_count = 0;
				default: ;
			endcase
			pending_q.push_back(w);
		endfunction

		task check_result(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
				logic f, logic tp, logic st);
			snap_word_t w;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending (x %0d y %0d)",
					sx, sy));
				return;
			end
			w = pending_q.pop_front();
			if (sx !== w.sx)
				report_mismatch($sformatf("snapped_x expected %0d got %0d", w.sx, sx));
			if (sy !== w.sy)
				report_mismatch($sformatf("snapped_y expected %0d got %0d", w.sy, sy));
			if (f !== w.found)
				report_mismatch($sformatf("found expected %0b got %0b", w.found, f));
			if (tp !== w.to_point)
				report_mismatch($sformatf("to_point expected %0b got %0b", w.to_point, tp));
			if (st !== w.status)
				report_mismatch($sformatf("status expected %0b got %0b", w.status, st));
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [MODE_W-1:0]         mode;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [RAD_W-1:0]          snap_radius;
	logic signed [COORD_W-1:0] line_position;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] snapped_x;
	logic signed [COORD_W-1:0] snapped_y;
	logic                      found;
	logic                      to_point;
	logic                      status;

	snap_scoreboard snap_sb = new();

	int unsigned items_sent        = 0;
	int unsigned sender_idle_pct   = 15;
	int unsigned receiver_idle_pct = 74;
	bit          hold_req          = 1'b0;
	bit          hold_done         = 1'b0;

	guide_line_snap #(
		.MAX_LINES(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.point_x(point_x),
		.point_y(point_y),
		.snap_radius(snap_radius),
		.line_position(line_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.snapped_x(snapped_x),
		.snapped_y(snapped_y),
		.found(found),
		.to_point(to_point),
		.status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// results are checked before the same edge's input is noted
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			snap_sb.check_result(snapped_x, snapped_y, found, to_point, status);
		if (arst_n && in_valid && in_ready)
			snap_sb.note_word(mode, point_x, point_y, snap_radius, line_position);
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				// long stall so the block backs up into its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	task automatic send_word(input logic [MODE_W-1:0] m, input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic [RAD_W-1:0] r,
			input logic signed [COORD_W-1:0] pos);
		if (items_sent < RANDOM_ITEMS / 3) begin
			sender_idle_pct   = 15;
			receiver_idle_pct = 74;
		end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
			sender_idle_pct   = 74;
			receiver_idle_pct = 15;
		end else begin
			sender_idle_pct   = 0;
			receiver_idle_pct = 0;
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		mode          <= m;
		point_x       <= px;
		point_y       <= py;
		snap_radius   <= r;
		line_position <= pos;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (m < MODE_SPARE_A)
			items_sent++;
	endtask

	function automatic logic signed [COORD_W-1:0] near_pos(logic signed [COORD_W-1:0] c,
			int step);
		int off;
		off = int'($urandom_range(40)) - 20;
		return c + off * step;
	endfunction

	function automatic logic [RAD_W-1:0] pick_radius(int step);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		if (roll < 18)
			return RAD_W'($urandom);
		return RAD_W'($urandom_range(24 * step));
	endfunction

	task automatic send_noise();
		case ($urandom_range(3))
			0: send_word(MODE_W'($urandom_range(MODE_SPARE_C, MODE_SPARE_A)), $urandom,
				$urandom, RAD_W'($urandom), $urandom);
			1: send_word(MODE_ADD_H, $urandom, $urandom, RAD_W'($urandom), $urandom);
			2: send_word(MODE_ADD_V, $urandom, $urandom, RAD_W'($urandom), $urandom);
			default: send_word(MODE_QUERY, $urandom, $urandom, RAD_W'($urandom), $urandom);
		endcase
	endtask

	task automatic run_directed();
		send_word(MODE_QUERY, 0, 0, RAD_MAX, 0);
		send_word(MODE_ADD_H, COORD_MAX, COORD_MIN, RAD_MAX, COORD_MAX);
		send_word(MODE_ADD_V, COORD_MIN, COORD_MAX, 0, COORD_MIN);
		// zero radius never snaps, even sitting on both lines
		send_word(MODE_QUERY, COORD_MIN, COORD_MAX, 0, 0);
		// both axes ten away with radius eleven: equal distances, x goes back
		send_word(MODE_QUERY, 32'sh8000_000A, 32'sh7FFF_FFF5, 11, 0);
		send_word(MODE_QUERY, COORD_MAX, COORD_MIN, RAD_MAX, COORD_MAX);
		send_word(MODE_SPARE_A, -1, 1, RAD_MAX, -1);
		send_word(MODE_SPARE_B, COORD_MIN, COORD_MAX, 0, COORD_MAX);
		send_word(MODE_SPARE_C, COORD_MAX, COORD_MIN, RAD_MAX, COORD_MIN);
		send_word(MODE_CLR_H, 5, 6, 7, 8);
		send_word(MODE_CLR_V, -5, -6, 7, -8);
		send_word(MODE_ADD_H, 0, 0, 0, 2560);
		send_word(MODE_ADD_H, 0, 0, 0, 3584);
		send_word(MODE_ADD_V, 0, 0, 0, -768);
		// y midway between two lines, the first added wins
		send_word(MODE_QUERY, -700, 3072, 600, 0);
		send_word(MODE_QUERY, -700, 3072, 515, 0);
		send_word(MODE_QUERY, -1268, 2600, 501, 0);
		send_word(MODE_QUERY, COORD_MAX, 2600, 100, 0);
		send_word(MODE_QUERY, -768, 3072, 1, 0);
		send_word(MODE_CLR_H, 0, 0, 0, 0);
		send_word(MODE_QUERY, -760, 2600, 256, 0);
		send_word(MODE_CLR_V, 0, 0, 0, 0);
	endtask

	// one neighborhood: optional clears, a batch of lines, then queries near them with stray noise words
	task automatic run_episode();
		logic signed [COORD_W-1:0] cx, cy;
		int                        step, n_h, n_v, n_q;
		step = ($urandom_range(2) == 0) ? 1 : ($urandom_range(1) ? 16 : 256);
		if ($urandom_range(3) == 0) begin
			cx = $urandom;
			cy = $urandom;
		end else begin
			cx = int'($urandom_range(2 ** 21)) - 2 ** 20;
			cy = int'($urandom_range(2 ** 21)) - 2 ** 20;
		end
		if ($urandom_range(1))
			send_word(MODE_CLR_H, $urandom, $urandom, RAD_W'($urandom), $urandom);
		if ($urandom_range(1))
			send_word(MODE_CLR_V, $urandom, $urandom, RAD_W'($urandom), $urandom);
		n_h = ($urandom_range(9) == 0) ? $urandom_range(70, 58) : $urandom_range(8);
		n_v = ($urandom_range(9) == 0) ? $urandom_range(70, 58) : $urandom_range(8);
		while (n_h + n_v > 0) begin
			if (n_h > 0 && (n_v == 0 || $urandom_range(1))) begin
				send_word(MODE_ADD_H, $urandom, $urandom, RAD_W'($urandom),
					near_pos(cy, step));
				n_h--;
			end else begin
				send_word(MODE_ADD_V, $urandom, $urandom, RAD_W'($urandom),
					near_pos(cx, step));
				n_v--;
			end
		end
		n_q = $urandom_range(12, 3);
		repeat (n_q) begin
			if ($urandom_range(9) == 0)
				send_noise();
			send_word(MODE_QUERY, near_pos(cx, step), near_pos(cy, step), pick_radius(step),
				$urandom);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_QUERY;
		point_x       = '0;
		point_y       = '0;
		snap_radius   = '0;
		line_position = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		while (items_sent < RANDOM_ITEMS) begin
			if (!hold_req && items_sent >= HOLD_AT)
				hold_req = 1'b1;
			run_episode();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (snap_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (snap_sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
